// ===== hw/rtl/plm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the landing step core.
// No dependencies; imported by the cell, median and top level modules.
package plm_pkg;

    typedef enum logic [1:0] {
        MOVE_HOLD    = 2'd0,
        MOVE_DESCEND = 2'd1,
        MOVE_CLIMB   = 2'd2
    } move_t;

    typedef enum logic {
        CFG_CENTRE_RADIUS = 1'b0,
        CFG_FINISH_HEIGHT = 1'b1
    } cfg_index_t;

    localparam int RADIUS_BITS = 23;
    localparam int HEIGHT_BITS = 24;
    localparam int CFG_BITS    = 24;

    localparam logic [RADIUS_BITS-1:0]        RADIUS_RESET = 23'd25600;
    localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_RESET = -24'sd51200;

    localparam int NONE_CODE = -256;
    localparam int LOST_TOL  = 2;

    typedef struct packed {
        logic load;
        logic fill;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/position_median_landing_step_core.sv =====
`timescale 1ns / 1ps
// Top level: source select, window cell chain, medians and move decision.
// Depends on plm_pkg, plm_cell and plm_median.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | primary_x/y/z, backup_x/y/z
//  out     | out_valid / out_stall| median_x/y/z, vertical_move, finished
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// One item per cycle unless out_stall holds it; results leave through the stages below.
// Stages: window cell shift, median rank select, move decision into out regs.
// Each stage advances when the one after it is empty or advancing.
// Reset clears stage valids and the primed flag and restores the configuration defaults.
module position_median_landing_step_core
    import plm_pkg::*;
#(
    parameter int WINDOW_LEN = 5,
    parameter int VALUE_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [VALUE_BITS-1:0] primary_x,
    input  logic signed [VALUE_BITS-1:0] primary_y,
    input  logic signed [VALUE_BITS-1:0] primary_z,
    input  logic signed [VALUE_BITS-1:0] backup_x,
    input  logic signed [VALUE_BITS-1:0] backup_y,
    input  logic signed [VALUE_BITS-1:0] backup_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] median_x,
    output logic signed [VALUE_BITS-1:0] median_y,
    output logic signed [VALUE_BITS-1:0] median_z,
    output logic [1:0]                   vertical_move,
    output logic                         finished,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data
);

    localparam int CMP_W = ((VALUE_BITS > HEIGHT_BITS) ? VALUE_BITS : HEIGHT_BITS) + 2;
    localparam logic signed [VALUE_BITS-1:0] NONE_V = VALUE_BITS'(NONE_CODE);
    localparam logic signed [CMP_W-1:0] NONE_W = CMP_W'(NONE_CODE);
    localparam logic signed [CMP_W-1:0] TOL_W  = CMP_W'(LOST_TOL);

    logic [RADIUS_BITS-1:0]        radius_reg, radius_next;
    logic signed [HEIGHT_BITS-1:0] height_reg, height_next;

    logic primed_reg, primed_next;
    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic o_valid_reg, o_valid_next;

    logic out_ready, b_ready, a_ready, accept;

    logic signed [VALUE_BITS-1:0] sel_x, sel_y, sel_z;
    logic                         use_backup;
    cell_ctl_t                    cell_ctl;

    logic signed [VALUE_BITS-1:0] win_x [WINDOW_LEN];
    logic signed [VALUE_BITS-1:0] win_y [WINDOW_LEN];
    logic signed [VALUE_BITS-1:0] win_z [WINDOW_LEN];

    logic signed [VALUE_BITS-1:0] med_x, med_y, med_z;

    logic signed [CMP_W-1:0] wx, wy, wz, dx, dy, dz, rad_p, rad_n, fin_h;
    logic                    lost, centred;
    move_t                   move_comb;
    logic                    fin_comb;

    logic signed [VALUE_BITS-1:0] mx_reg, my_reg, mz_reg;
    logic signed [VALUE_BITS-1:0] mx_next, my_next, mz_next;
    move_t                        move_reg, move_next;
    logic                         fin_reg, fin_next;

    // handshake
    assign out_ready = !o_valid_reg || !out_stall;
    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign accept    = in_valid && a_ready;
    assign in_stall  = !a_ready;

    // source select
    assign use_backup = (primary_x == NONE_V) && (primary_y == NONE_V) && (primary_z == NONE_V);
    assign sel_x = use_backup ? backup_x : primary_x;
    assign sel_y = use_backup ? backup_y : primary_y;
    assign sel_z = use_backup ? backup_z : primary_z;

    assign cell_ctl.load = accept;
    assign cell_ctl.fill = !primed_reg;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_LEN; gi++)
        begin : g_cell
            if (gi == WINDOW_LEN - 1)
            begin : g_last
                plm_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                    .clk    (clk),
                    .ctl    (cell_ctl),
                    .new_x  (sel_x),
                    .new_y  (sel_y),
                    .new_z  (sel_z),
                    .next_x (sel_x),
                    .next_y (sel_y),
                    .next_z (sel_z),
                    .slot_x (win_x[gi]),
                    .slot_y (win_y[gi]),
                    .slot_z (win_z[gi])
                );
            end
            else
            begin : g_mid
                plm_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                    .clk    (clk),
                    .ctl    (cell_ctl),
                    .new_x  (sel_x),
                    .new_y  (sel_y),
                    .new_z  (sel_z),
                    .next_x (win_x[gi+1]),
                    .next_y (win_y[gi+1]),
                    .next_z (win_z[gi+1]),
                    .slot_x (win_x[gi]),
                    .slot_y (win_y[gi]),
                    .slot_z (win_z[gi])
                );
            end
        end
    endgenerate

    plm_median #(.WINDOW_LEN(WINDOW_LEN), .VALUE_BITS(VALUE_BITS)) u_med_x (
        .clk    (clk),
        .en     (a_valid_reg && b_ready),
        .win    (win_x),
        .median (med_x)
    );

    plm_median #(.WINDOW_LEN(WINDOW_LEN), .VALUE_BITS(VALUE_BITS)) u_med_y (
        .clk    (clk),
        .en     (a_valid_reg && b_ready),
        .win    (win_y),
        .median (med_y)
    );

    plm_median #(.WINDOW_LEN(WINDOW_LEN), .VALUE_BITS(VALUE_BITS)) u_med_z (
        .clk    (clk),
        .en     (a_valid_reg && b_ready),
        .win    (win_z),
        .median (med_z)
    );

    // move decision
    always_comb
    begin
        wx    = CMP_W'(med_x);
        wy    = CMP_W'(med_y);
        wz    = CMP_W'(med_z);
        dx    = wx - NONE_W;
        dy    = wy - NONE_W;
        dz    = wz - NONE_W;
        rad_p = CMP_W'($signed({1'b0, radius_reg}));
        rad_n = -rad_p;
        fin_h = CMP_W'(height_reg);
        lost  = (dx >= -TOL_W) && (dx <= TOL_W) && (dy >= -TOL_W) && (dy <= TOL_W)
             && (dz >= -TOL_W) && (dz <= TOL_W);
        centred = (wx < rad_p) && (wx > rad_n) && (wy < rad_p) && (wy > rad_n);
        if (lost)
        begin
            move_comb = MOVE_CLIMB;
            fin_comb  = 1'b0;
        end
        else
        begin
            move_comb = centred ? MOVE_DESCEND : MOVE_HOLD;
            fin_comb  = (wz >= fin_h);
        end
    end

    always_comb
    begin
        mx_next   = mx_reg;
        my_next   = my_reg;
        mz_next   = mz_reg;
        move_next = move_reg;
        fin_next  = fin_reg;
        if (b_valid_reg && out_ready)
        begin
            mx_next   = med_x;
            my_next   = med_y;
            mz_next   = med_z;
            move_next = move_comb;
            fin_next  = fin_comb;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        mz_reg   <= mz_next;
        move_reg <= move_next;
        fin_reg  <= fin_next;
    end

    // control state
    always_comb
    begin
        primed_next  = primed_reg || accept;
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        o_valid_next = o_valid_reg;
        if (a_ready)
        begin
            a_valid_next = accept;
        end
        if (b_ready)
        begin
            b_valid_next = a_valid_reg;
        end
        if (out_ready)
        begin
            o_valid_next = b_valid_reg;
        end
        radius_next = radius_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CENTRE_RADIUS: radius_next = cfg_data[RADIUS_BITS-1:0];
                CFG_FINISH_HEIGHT: height_next = $signed(cfg_data[HEIGHT_BITS-1:0]);
                default:           radius_next = radius_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            radius_reg  <= RADIUS_RESET;
            height_reg  <= HEIGHT_RESET;
        end
        else
        begin
            primed_reg  <= primed_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
            radius_reg  <= radius_next;
            height_reg  <= height_next;
        end
    end

    assign out_valid     = o_valid_reg;
    assign median_x      = mx_reg;
    assign median_y      = my_reg;
    assign median_z      = mz_reg;
    assign vertical_move = move_reg;
    assign finished      = fin_reg;

endmodule

// ===== hw/rtl/plm_cell.sv =====
`timescale 1ns / 1ps
// One x, y, z slot: takes the new sample when filling, else its neighbor's.
// Depends on plm_pkg for the cell control struct.
module plm_cell
    import plm_pkg::*;
#(
    parameter int VALUE_BITS = 24
)
(
    input  logic                         clk,
    input  cell_ctl_t                    ctl,
    input  logic signed [VALUE_BITS-1:0] new_x,
    input  logic signed [VALUE_BITS-1:0] new_y,
    input  logic signed [VALUE_BITS-1:0] new_z,
    input  logic signed [VALUE_BITS-1:0] next_x,
    input  logic signed [VALUE_BITS-1:0] next_y,
    input  logic signed [VALUE_BITS-1:0] next_z,
    output logic signed [VALUE_BITS-1:0] slot_x,
    output logic signed [VALUE_BITS-1:0] slot_y,
    output logic signed [VALUE_BITS-1:0] slot_z
);

    logic signed [VALUE_BITS-1:0] x_reg, y_reg, z_reg;
    logic signed [VALUE_BITS-1:0] x_next, y_next, z_next;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (ctl.load)
        begin
            if (ctl.fill)
            begin
                x_next = new_x;
                y_next = new_y;
                z_next = new_z;
            end
            else
            begin
                x_next = next_x;
                y_next = next_y;
                z_next = next_z;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign slot_x = x_reg;
    assign slot_y = y_reg;
    assign slot_z = z_reg;

endmodule

// ===== hw/rtl/plm_median.sv =====
`timescale 1ns / 1ps
// Registered median of one axis window by rank counting with index tie break.
// Depends on plm_pkg (wildcard import, no items used beyond the house style).
module plm_median
    import plm_pkg::*;
#(
    parameter int WINDOW_LEN = 5,
    parameter int VALUE_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [VALUE_BITS-1:0] win [WINDOW_LEN],
    output logic signed [VALUE_BITS-1:0] median
);

    localparam int CNT_W = $clog2(WINDOW_LEN);
    localparam logic [CNT_W-1:0] HALF = CNT_W'(WINDOW_LEN / 2);

    logic [CNT_W-1:0]             rank [WINDOW_LEN];
    logic signed [VALUE_BITS-1:0] median_reg, median_next;

    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_LEN; j++)
            begin
                if (j != i)
                begin
                    if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)))
                    begin
                        rank[i] = rank[i] + CNT_W'(1);
                    end
                end
            end
        end
        median_next = median_reg;
        if (en)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                if (rank[i] == HALF)
                begin
                    median_next = win[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
    end

    assign median = median_reg;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for position_median_landing_step_core: drives position fixes,
// predicts the median window and move decision, and compares every result in order.
// Depends on plm_pkg and the core RTL.
module testbench
    import plm_pkg::*;
();

    localparam int VB = 24;
    localparam int WL = 5;
    localparam int NO_FIX = -256;
    localparam int LOST_SLACK = 2;

    typedef struct packed {
        logic signed [VB-1:0] px;
        logic signed [VB-1:0] py;
        logic signed [VB-1:0] pz;
        logic signed [VB-1:0] bx;
        logic signed [VB-1:0] by;
        logic signed [VB-1:0] bz;
    } fix_pair_t;

    typedef struct packed {
        logic signed [VB-1:0] mx;
        logic signed [VB-1:0] my;
        logic signed [VB-1:0] mz;
        move_t                move;
        logic                 done;
    } landing_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [VB-1:0] primary_x = '0;
    logic signed [VB-1:0] primary_y = '0;
    logic signed [VB-1:0] primary_z = '0;
    logic signed [VB-1:0] backup_x = '0;
    logic signed [VB-1:0] backup_y = '0;
    logic signed [VB-1:0] backup_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [VB-1:0] median_x;
    logic signed [VB-1:0] median_y;
    logic signed [VB-1:0] median_z;
    logic [1:0] vertical_move;
    logic finished;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    fix_pair_t pending_fixes[$];
    landing_result_t expected_steps[$];
    fix_pair_t offered_fix;
    landing_result_t next_due;

    logic signed [VB-1:0] track_win [3][WL];
    bit track_primed = 1'b0;
    logic [RADIUS_BITS-1:0] cfg_radius = RADIUS_RESET;
    logic signed [HEIGHT_BITS-1:0] cfg_height = HEIGHT_RESET;

    int failures = 0;
    int results_seen = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_off_left = 0;
    bit hold_off_done = 1'b0;
    bit calm_tail = 1'b0;

    position_median_landing_step_core #(
        .WINDOW_LEN(WL),
        .VALUE_BITS(VB)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .primary_x    (primary_x),
        .primary_y    (primary_y),
        .primary_z    (primary_z),
        .backup_x     (backup_x),
        .backup_y     (backup_y),
        .backup_z     (backup_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_x     (median_x),
        .median_y     (median_y),
        .median_z     (median_z),
        .vertical_move(vertical_move),
        .finished     (finished),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [VB-1:0] slide_median(input int axis,
                                                          input logic signed [VB-1:0] v);
        logic signed [VB-1:0] s [WL];
        logic signed [VB-1:0] t;
        int i;
        int j;
        for (i = 0; i < WL; i++)
        begin
            if (!track_primed)
                track_win[axis][i] = v;
            else if (i < WL - 1)
                track_win[axis][i] = track_win[axis][i + 1];
            else
                track_win[axis][i] = v;
        end
        for (i = 0; i < WL; i++)
            s[i] = track_win[axis][i];
        for (i = 0; i < WL - 1; i++)
            for (j = 0; j < WL - 1 - i; j++)
                if (s[j] > s[j + 1])
                begin
                    t = s[j];
                    s[j] = s[j + 1];
                    s[j + 1] = t;
                end
        return s[WL / 2];
    endfunction

    task automatic predict_landing_step(input fix_pair_t f);
        landing_result_t r;
        longint mx;
        longint my;
        longint mz;
        longint rad;
        longint hgt;
        bit lost;
        if (f.px == NO_FIX && f.py == NO_FIX && f.pz == NO_FIX)
        begin
            r.mx = slide_median(0, f.bx);
            r.my = slide_median(1, f.by);
            r.mz = slide_median(2, f.bz);
        end
        else
        begin
            r.mx = slide_median(0, f.px);
            r.my = slide_median(1, f.py);
            r.mz = slide_median(2, f.pz);
        end
        track_primed = 1'b1;
        mx = $signed(r.mx);
        my = $signed(r.my);
        mz = $signed(r.mz);
        rad = cfg_radius;
        hgt = cfg_height;
        lost = mx >= NO_FIX - LOST_SLACK && mx <= NO_FIX + LOST_SLACK
            && my >= NO_FIX - LOST_SLACK && my <= NO_FIX + LOST_SLACK
            && mz >= NO_FIX - LOST_SLACK && mz <= NO_FIX + LOST_SLACK;
        if (lost)
            r.move = MOVE_CLIMB;
        else if (mx > -rad && mx < rad && my > -rad && my < rad)
            r.move = MOVE_DESCEND;
        else
            r.move = MOVE_HOLD;
        r.done = !lost && mz >= hgt;
        expected_steps.push_back(r);
    endtask

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Sender: hold a stalled request, otherwise idle in bursts or offer the next fix.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                predict_landing_step(offered_fix);
            if (in_valid && in_stall)
            begin
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 14);
                in_valid <= 1'b0;
            end
            else if (pending_fixes.size() > 0)
            begin
                offered_fix = pending_fixes.pop_front();
                primary_x <= offered_fix.px;
                primary_y <= offered_fix.py;
                primary_z <= offered_fix.pz;
                backup_x <= offered_fix.bx;
                backup_y <= offered_fix.by;
                backup_z <= offered_fix.bz;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: check each accepted result, stall in bursts and once for a long stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_steps.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d %0d",
                             $time, median_x, median_y, median_z, vertical_move, finished);
                end
                else
                begin
                    next_due = expected_steps.pop_front();
                    check_field("median_x", $signed(next_due.mx), median_x);
                    check_field("median_y", $signed(next_due.my), median_y);
                    check_field("median_z", $signed(next_due.mz), median_z);
                    check_field("vertical_move", next_due.move, vertical_move);
                    check_field("finished", next_due.done, finished);
                    results_seen++;
                end
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_stall <= 1'b1;
            end
            else if (results_seen == 400 && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                hold_off_left = 80;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (!calm_tail && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 14);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic push_fix(input int px, input int py, input int pz,
                            input int bx, input int by, input int bz);
        fix_pair_t f;
        f.px = VB'(px);
        f.py = VB'(py);
        f.pz = VB'(pz);
        f.bx = VB'(bx);
        f.by = VB'(by);
        f.bz = VB'(bz);
        pending_fixes.push_back(f);
    endtask

    function automatic int pick_coord();
        int v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = int'(cfg_radius) + int'($urandom_range(0, 4)) - 2;
            2: v = int'($urandom_range(0, 2000)) - 1000;
            3: v = NO_FIX + int'($urandom_range(0, 8)) - 4;
            default: v = int'(cfg_height) + int'($urandom_range(0, 4)) - 2;
        endcase
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    task automatic queue_random_fixes(input int count);
        int n;
        int mode;
        int run;
        n = 0;
        while (n < count)
        begin
            mode = $urandom_range(0, 9);
            run = $urandom_range(1, 8);
            repeat (run)
            begin
                case (mode)
                    0, 1, 2, 3:
                        push_fix(pick_coord(), pick_coord(), pick_coord(),
                                 $urandom, $urandom, $urandom);
                    4, 5:
                        push_fix(NO_FIX, NO_FIX, NO_FIX, pick_coord(), pick_coord(), pick_coord());
                    6:
                        push_fix(NO_FIX, NO_FIX, NO_FIX, NO_FIX + int'($urandom_range(0, 6)) - 3,
                                 NO_FIX + int'($urandom_range(0, 6)) - 3,
                                 NO_FIX + int'($urandom_range(0, 6)) - 3);
                    7:
                        push_fix(NO_FIX + int'($urandom_range(0, 6)) - 3,
                                 NO_FIX + int'($urandom_range(0, 6)) - 3,
                                 NO_FIX + int'($urandom_range(0, 6)) - 3,
                                 $urandom, $urandom, $urandom);
                    8:
                        push_fix($urandom_range(0, 1) ? NO_FIX : pick_coord(),
                                 $urandom_range(0, 1) ? NO_FIX : pick_coord(),
                                 $urandom_range(0, 1) ? NO_FIX : pick_coord(),
                                 pick_coord(), pick_coord(), pick_coord());
                    default:
                        push_fix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                endcase
                n++;
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_fixes.size() != 0 || in_valid || expected_steps.size() != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_settings(input logic [RADIUS_BITS-1:0] radius,
                                  input logic signed [HEIGHT_BITS-1:0] height);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CENTRE_RADIUS;
        cfg_data <= {1'($urandom_range(0, 1)), radius};
        @(posedge clk);
        cfg_index <= CFG_FINISH_HEIGHT;
        cfg_data <= height;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_radius = radius;
        cfg_height = height;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        push_fix(256, 512, -1000, 0, 0, 0);
        repeat (3) push_fix(NO_FIX, NO_FIX, NO_FIX, 8388607, -8388608, 8388607);
        repeat (2) push_fix(NO_FIX, NO_FIX, NO_FIX, -8388608, 8388607, -8388608);
        repeat (3) push_fix(NO_FIX, NO_FIX, NO_FIX, NO_FIX, NO_FIX, NO_FIX);
        repeat (2) push_fix(NO_FIX, NO_FIX, NO_FIX, -254, -258, -255);
        repeat (3) push_fix(NO_FIX, NO_FIX, NO_FIX, -259, NO_FIX, NO_FIX);
        push_fix(NO_FIX, NO_FIX, 0, 7, 7, 7);
        repeat (3) push_fix(25599, -25599, -51200, 1, 2, 3);
        repeat (3) push_fix(25600, 0, -51201, 4, 5, 6);
        repeat (3) push_fix(8388607, -8388608, 8388607, -8388608, 8388607, -8388608);
        queue_random_fixes(100);
        drain();

        write_settings(23'd0, 24'sh7FFFFF);
        queue_random_fixes(100);
        drain();

        write_settings(23'h7FFFFF, 24'sh800000);
        queue_random_fixes(120);
        drain();

        write_settings(RADIUS_BITS'($urandom_range(0, 60000)),
                       HEIGHT_BITS'(int'($urandom_range(0, 200000)) - 100000));
        queue_random_fixes(300);
        drain();

        calm_tail = 1'b1;
        write_settings(RADIUS_RESET, HEIGHT_RESET);
        queue_random_fixes(150);
        drain();

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== position_median_landing_step_core.f =====
hw/rtl/plm_pkg.sv
hw/rtl/plm_cell.sv
hw/rtl/plm_median.sv
hw/rtl/position_median_landing_step_core.sv
verif/testbench.sv
